>>> rtl/hnst_pkg.sv
// ----------------------------------------------------------------------------
// hnst_pkg
// shared types and constants for the hashed name slot table
// ----------------------------------------------------------------------------
package hnst_pkg;

	localparam int MAX_SLOTS   = 1024;
	localparam int SLOT_W      = $clog2(MAX_SLOTS);
	localparam int HANDLE_BITS = 32;
	localparam int COUNT_W     = 11;
	localparam int HASH_W      = 32;
	localparam int HASH_CNT_W  = $clog2(HASH_W);
	localparam int MIX_SH_W    = 4;
	localparam int ENTRY_W     = HANDLE_BITS + 2;

	localparam logic [1:0] REQ_HASH   = 2'd0;
	localparam logic [1:0] REQ_INSERT = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_GET    = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OCCUPIED = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_BAD_KIND = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;

	localparam logic [1:0] KIND_MAX = 2'd1;

	localparam logic [COUNT_W-1:0] SLOT_COUNT_RESET = COUNT_W'(MAX_SLOTS);

	typedef struct packed {
		logic [1:0]             op;
		logic [HASH_W-1:0]      hash;
		logic [HANDLE_BITS-1:0] handle;
		logic [1:0]             kind;
		logic [SLOT_W-1:0]      index;
	} cmd_t;

endpackage

>>> rtl/hnst_front.sv
// ----------------------------------------------------------------------------
// hnst_front
// takes requests, folds name bytes into the two mixers, queues commands
// ----------------------------------------------------------------------------
module hnst_front import hnst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   enable,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             req_type,
	input  logic [7:0]             name_byte,
	input  logic                   last_byte,
	input  logic [HANDLE_BITS-1:0] payload_handle,
	input  logic [1:0]             entry_kind,
	input  logic [SLOT_W-1:0]      slot_index,
	output logic                   push,
	output cmd_t                   push_cmd,
	input  logic                   push_ready
);

	logic [HASH_W-1:0] mix_a_q, mix_b_q, mix_a_n, mix_b_n, word;
	logic [7:0]        held_byte_q, lo_byte, hi_byte;
	logic              held_valid_q, accept, is_get;

	assign in_ready = enable & push_ready;
	assign accept   = in_valid & in_ready;
	assign is_get   = (req_type == REQ_GET);

	always_comb begin
		if (held_valid_q) begin
			lo_byte = held_byte_q;
			hi_byte = name_byte;
		end else begin
			lo_byte = name_byte;
			hi_byte = 8'd0;
		end
		word    = {hi_byte, lo_byte, hi_byte, lo_byte};
		mix_a_n = mix_a_q ^ (word >> mix_b_q[MIX_SH_W-1:0]);
		mix_b_n = mix_b_q ^ (word >> mix_a_n[MIX_SH_W-1:0]);
	end

	assign push            = accept & (is_get | last_byte);
	assign push_cmd.op     = req_type;
	assign push_cmd.hash   = mix_a_n ^ mix_b_n;
	assign push_cmd.handle = payload_handle;
	assign push_cmd.kind   = entry_kind;
	assign push_cmd.index  = slot_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_a_q      <= '0;
			mix_b_q      <= '0;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
		end else if (accept && !is_get) begin
			if (last_byte) begin
				mix_a_q      <= '0;
				mix_b_q      <= '0;
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
			end else if (held_valid_q) begin
				mix_a_q      <= mix_a_n;
				mix_b_q      <= mix_b_n;
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
			end else begin
				held_byte_q  <= name_byte;
				held_valid_q <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/hnst_fifo.sv
// ----------------------------------------------------------------------------
// hnst_fifo
// two-entry command queue between the front and the back
// ----------------------------------------------------------------------------
module hnst_fifo import hnst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic push_ready,
	input  logic pop,
	output logic pop_valid,
	output cmd_t pop_cmd
);

	cmd_t       buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = buf_q[rd_ptr_q];
	assign do_push    = push & push_ready;
	assign do_pop     = pop & pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/hnst_back.sv
// ----------------------------------------------------------------------------
// hnst_back
// slot reduction by serial remainder, slot memory access, result register
// ----------------------------------------------------------------------------
module hnst_back import hnst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [COUNT_W-1:0]     slot_count,
	output logic                   clearing,
	input  logic                   q_valid,
	input  cmd_t                   q_cmd,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [HANDLE_BITS-1:0] out_handle,
	output logic                   out_kind
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_DEC   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]             state_q;
	logic [SLOT_W-1:0]      clr_q;
	logic [HASH_CNT_W-1:0]  cnt_q;
	cmd_t                   cmd_q;
	logic [HASH_W-1:0]      dividend_q;
	logic [SLOT_W-1:0]      rem_q, rem_n, slot_q;
	logic [ENTRY_W-1:0]     mem [MAX_SLOTS];
	logic [ENTRY_W-1:0]     rdata_q, wdata;
	logic [SLOT_W-1:0]      waddr;
	logic                   we, used, kind_bad, idx_range;
	logic [COUNT_W-1:0]     live, trial;
	logic [2:0]             status_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic                   kind_q;

	always_comb begin
		if (slot_count == '0) begin
			live = COUNT_W'(1);
		end else if (slot_count > SLOT_COUNT_RESET) begin
			live = SLOT_COUNT_RESET;
		end else begin
			live = slot_count;
		end
	end

	assign idx_range = ({1'b0, q_cmd.index} >= live);
	assign trial     = {rem_q, dividend_q[HASH_W-1]};
	assign rem_n     = (trial >= live) ? SLOT_W'(trial - live) : trial[SLOT_W-1:0];
	assign used      = rdata_q[ENTRY_W-1];
	assign kind_bad  = (cmd_q.kind > KIND_MAX);
	assign clearing  = (state_q == S_CLEAR);
	assign q_pop     = (state_q == S_IDLE) & q_valid;
	assign out_valid = (state_q == S_OUT);
	assign status    = status_q;
	assign slot      = slot_q;
	assign out_handle = handle_q;
	assign out_kind  = kind_q;

	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = '0;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
		end else if (state_q == S_DEC) begin
			if (cmd_q.op == REQ_INSERT && !kind_bad && !used) begin
				we    = 1'b1;
				wdata = {1'b1, cmd_q.kind[0], cmd_q.handle};
			end else if (cmd_q.op == REQ_REMOVE && used) begin
				we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (q_valid) begin
						if (q_cmd.op == REQ_GET) begin
							state_q <= idx_range ? S_OUT : S_RD;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + HASH_CNT_W'(1);
					if (&cnt_q) begin
						state_q <= (cmd_q.op == REQ_HASH) ? S_OUT : S_RD;
					end
				end
				S_RD:  state_q <= S_DEC;
				S_DEC: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					cmd_q      <= q_cmd;
					dividend_q <= q_cmd.hash;
					rem_q      <= '0;
					slot_q     <= q_cmd.index;
					status_q   <= (q_cmd.op == REQ_GET && idx_range) ? ST_RANGE : ST_OK;
					handle_q   <= '0;
					kind_q     <= 1'b0;
				end
			end
			S_DIV: begin
				dividend_q <= dividend_q << 1;
				rem_q      <= rem_n;
				if (&cnt_q) begin
					slot_q <= rem_n;
				end
			end
			S_DEC: begin
				case (cmd_q.op)
					REQ_GET: begin
						if (used) begin
							status_q <= ST_OK;
							handle_q <= rdata_q[HANDLE_BITS-1:0];
							kind_q   <= rdata_q[HANDLE_BITS];
						end else begin
							status_q <= ST_EMPTY;
						end
					end
					REQ_INSERT: begin
						if (kind_bad) begin
							status_q <= ST_BAD_KIND;
						end else if (used) begin
							status_q <= ST_OCCUPIED;
						end else begin
							status_q <= ST_OK;
						end
					end
					REQ_REMOVE: status_q <= used ? ST_OK : ST_EMPTY;
					default:    status_q <= ST_OK;
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/hashed_name_slot_table.sv
// ----------------------------------------------------------------------------
// hashed_name_slot_table
// direct-mapped name table: byte-stream hashing, insert, remove and get
//
//   channel  direction  handshake            contents
//   in       sink       in_valid/in_ready    req_type name_byte last_byte
//                                            payload_handle entry_kind
//                                            slot_index
//   out      source     out_valid/out_ready  status slot out_handle out_kind
//   cfg      sink       cfg_valid/cfg_ready  cfg_data = slot_count
//
// name bytes are taken one per cycle while in_ready is high; a two-entry queue sits behind the front
// a last byte's command leaves the queue, runs the serial remainder, then the
// slot memory read and update (skipped by a hash), then the output register
// a get skips the remainder; one with an index out of range skips the memory too
// after reset a clearing pass over every slot memory entry holds in_ready low
// a stalled output holds the back end; the front runs on until the queue fills
// ----------------------------------------------------------------------------
module hashed_name_slot_table import hnst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             req_type,
	input  logic [7:0]             name_byte,
	input  logic                   last_byte,
	input  logic [HANDLE_BITS-1:0] payload_handle,
	input  logic [1:0]             entry_kind,
	input  logic [SLOT_W-1:0]      slot_index,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             status,
	output logic [SLOT_W-1:0]      slot,
	output logic [HANDLE_BITS-1:0] out_handle,
	output logic                   out_kind,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [COUNT_W-1:0]     cfg_data
);

	logic [COUNT_W-1:0] slot_count_q;
	logic               clearing, push, push_ready, q_valid, q_pop;
	cmd_t               push_cmd, q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slot_count_q <= cfg_data;
		end
	end

	hnst_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.enable         (~clearing),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.name_byte      (name_byte),
		.last_byte      (last_byte),
		.payload_handle (payload_handle),
		.entry_kind     (entry_kind),
		.slot_index     (slot_index),
		.push           (push),
		.push_cmd       (push_cmd),
		.push_ready     (push_ready)
	);

	hnst_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_cmd    (q_cmd)
	);

	hnst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slot_count (slot_count_q),
		.clearing   (clearing),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.slot       (slot),
		.out_handle (out_handle),
		.out_kind   (out_kind)
	);

endmodule

>>> rtl/hnst_checker.sv
// ----------------------------------------------------------------------------
// hnst_checker
// port-level checks on the hashed name slot table
// ----------------------------------------------------------------------------
module hnst_checker import hnst_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [2:0]             status,
	input logic [SLOT_W-1:0]      slot,
	input logic [HANDLE_BITS-1:0] out_handle,
	input logic                   out_kind
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
			&& $stable(out_handle) && $stable(out_kind))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result shown again right after delivery");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_handle == '0 && out_kind == 1'b0)
		else $error("failed request carries entry data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_RANGE)
		else $error("status out of range");

	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("request taken during clearing pass");

endmodule

bind hashed_name_slot_table hnst_checker u_hnst_checker (.*);
